[design/afc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_pkg
// Types and constants shared by the box build and frustum cull unit.
// ----------------------------------------------------------------------------
package afc_pkg;

	localparam int CW          = 32;
	localparam int HW          = CW - 1;
	localparam int PLANE_COUNT = 6;
	localparam int ROW_COUNT   = 3;
	localparam int MUL_W       = CW + 1;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int ACC_W       = PROD_W + 2;
	localparam int Q_DEPTH     = 2;

	localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

	typedef enum logic [1:0] {
		OP_VERTEX = 2'd0,
		OP_ROW    = 2'd1,
		OP_PLANE  = 2'd2,
		OP_RSVD   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_ACC,
		S_DONE
	} back_state_t;

	typedef struct packed {
		logic [1:0]          opcode;
		logic [2:0]          slot;
		logic signed [CW-1:0] val_a;
		logic signed [CW-1:0] val_b;
		logic signed [CW-1:0] val_c;
		logic signed [CW-1:0] val_d;
		logic                last_vertex;
	} item_t;

	typedef struct packed {
		logic                inside_res;
		logic signed [CW-1:0] center_x;
		logic signed [CW-1:0] center_y;
		logic signed [CW-1:0] center_z;
		logic [HW-1:0]       half_x;
		logic [HW-1:0]       half_y;
		logic [HW-1:0]       half_z;
	} result_t;

	typedef struct packed {
		logic signed [CW-1:0] a;
		logic signed [CW-1:0] b;
		logic signed [CW-1:0] c;
		logic signed [CW-1:0] d;
	} coef_t;

	typedef struct packed {
		logic signed [2:0][CW-1:0] c;
		logic [2:0][HW-1:0]        h;
	} job_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic empty;
	} q_ctrl_t;

endpackage

[design/afc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_queue
// Short job queue between the box builder and the cull sequencer.
// ----------------------------------------------------------------------------
module afc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  afc_pkg::job_t push_job,
	input  logic          pop,
	output afc_pkg::job_t pop_job,
	output logic          full,
	output logic          empty
);
	import afc_pkg::*;

	localparam int PW = $clog2(Q_DEPTH);

	job_t          mem_q [Q_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full    = (count_q == (PW+1)'(Q_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

[design/afc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_front
// Accepts items, grows the running box and holds the matrix and plane stores.
// ----------------------------------------------------------------------------
module afc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  afc_pkg::item_t item,
	output logic           busy,
	input  logic           back_idle,
	input  logic           q_full,
	input  logic           q_empty,
	output logic           push,
	output afc_pkg::job_t  push_job,
	output afc_pkg::coef_t rows [afc_pkg::ROW_COUNT],
	output afc_pkg::coef_t planes [afc_pkg::PLANE_COUNT]
);
	import afc_pkg::*;

	logic signed [2:0][CW-1:0] min_q, max_q, vtx, nmin, nmax;
	item_t                     pend_q;
	logic                      pend_valid_q;
	logic                      accept, load_ok, can_apply, wr_en;
	item_t                     src;
	logic signed [CW:0]        sum, diff;
	coef_t                     rows_q [ROW_COUNT];
	coef_t                     planes_q [PLANE_COUNT];

	assign busy      = q_full | pend_valid_q;
	assign accept    = start & ~busy;
	assign load_ok   = accept & (((item.opcode == OP_ROW) && (item.slot < 3'(ROW_COUNT)))
		|| ((item.opcode == OP_PLANE) && (item.slot < 3'(PLANE_COUNT))));
	assign can_apply = q_empty & back_idle;
	assign wr_en     = can_apply & (pend_valid_q | load_ok);
	assign src       = pend_valid_q ? pend_q : item;
	assign push      = accept & (item.opcode == OP_VERTEX) & item.last_vertex;
	assign vtx       = {item.val_c, item.val_b, item.val_a};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nmin[i]       = ($signed(vtx[i]) < $signed(min_q[i])) ? vtx[i] : min_q[i];
			nmax[i]       = ($signed(vtx[i]) > $signed(max_q[i])) ? vtx[i] : max_q[i];
			sum           = {nmin[i][CW-1], nmin[i]} + {nmax[i][CW-1], nmax[i]};
			diff          = {nmax[i][CW-1], nmax[i]} - {nmin[i][CW-1], nmin[i]};
			push_job.c[i] = sum[CW:1];
			push_job.h[i] = diff[CW-1:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q        <= {3{COORD_MAX}};
			max_q        <= {3{COORD_MIN}};
			pend_valid_q <= 1'b0;
		end else begin
			if (accept && (item.opcode == OP_VERTEX)) begin
				if (item.last_vertex) begin
					min_q <= {3{COORD_MAX}};
					max_q <= {3{COORD_MIN}};
				end else begin
					min_q <= nmin;
					max_q <= nmax;
				end
			end
			if (load_ok && !can_apply) begin
				pend_valid_q <= 1'b1;
			end else if (pend_valid_q && can_apply) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok && !can_apply) begin
			pend_q <= item;
		end
		if (wr_en) begin
			if (src.opcode == OP_ROW) begin
				rows_q[src.slot[1:0]] <= '{src.val_a, src.val_b, src.val_c, src.val_d};
			end else begin
				planes_q[src.slot] <= '{src.val_a, src.val_b, src.val_c, src.val_d};
			end
		end
	end

	assign rows   = rows_q;
	assign planes = planes_q;

endmodule

[design/afc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_back
// Transforms the box center and tests it against the frustum planes with one
// shared multiplier.
// ----------------------------------------------------------------------------
module afc_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  afc_pkg::job_t    job,
	output logic             pop,
	output logic             idle,
	input  afc_pkg::coef_t   rows [afc_pkg::ROW_COUNT],
	input  afc_pkg::coef_t   planes [afc_pkg::PLANE_COUNT],
	output logic             done,
	output afc_pkg::result_t result
);
	import afc_pkg::*;

	back_state_t               state_q, state_d;
	logic [3:0]                grp_q;
	logic [2:0]                term_q;
	logic signed [ACC_W-1:0]   acc_q, sum, shifted, init_next, init_first;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [MUL_W-1:0]   op_a, op_b;
	logic signed [2:0][CW-1:0] c_q, g_q;
	logic [2:0][HW-1:0]        h_q;
	logic                      inside_q, last_term, sat_ok;
	logic [2:0]                pl_idx, pl_next;
	logic [1:0]                ax;
	logic signed [CW-1:0]      row_e, pl_e, g_sat;
	coef_t                     rw, pl;

	function automatic logic signed [ACC_W-1:0] init_val(input coef_t r, input logic is_row);
		logic signed [ACC_W-1:0] v;
		v = {{(ACC_W-CW){r.d[CW-1]}}, r.d} <<< FRAC_BITS;
		return is_row ? v : -v;
	endfunction

	function automatic logic signed [CW-1:0] pick(input coef_t r, input logic [1:0] k);
		logic signed [CW-1:0] v;
		unique case (k)
			2'd0:    v = r.a;
			2'd1:    v = r.b;
			default: v = r.c;
		endcase
		return v;
	endfunction

	assign pl_idx    = (grp_q >= 4'd3) ? 3'(grp_q - 4'd3) : '0;
	assign pl_next   = ((grp_q >= 4'd2) && (grp_q < 4'd8)) ? 3'(grp_q - 4'd2) : '0;
	assign ax        = (term_q >= 3'd3) ? 2'(term_q - 3'd3) : term_q[1:0];
	assign rw        = rows[grp_q[1:0] == 2'd3 ? 2'd0 : grp_q[1:0]];
	assign pl        = planes[pl_idx];
	assign row_e     = pick(rw, ax);
	assign pl_e      = pick(pl, ax);
	assign last_term = (grp_q < 4'd3) ? (term_q == 3'd2) : (term_q == 3'd5);
	assign sum       = acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
	assign shifted   = sum >>> FRAC_BITS;
	assign sat_ok    = (&shifted[ACC_W-1:CW-1]) | ~(|shifted[ACC_W-1:CW-1]);
	assign g_sat     = sat_ok ? shifted[CW-1:0] : (shifted[ACC_W-1] ? COORD_MIN : COORD_MAX);
	assign init_first = init_val(rows[0], 1'b1);
	assign init_next = (grp_q < 4'd2) ? init_val(rows[2'(grp_q + 4'd1)], 1'b1)
		: init_val(planes[pl_next], 1'b0);

	always_comb begin
		if (grp_q < 4'd3) begin
			op_a = {row_e[CW-1], row_e};
			op_b = {c_q[ax][CW-1], c_q[ax]};
		end else if (term_q < 3'd3) begin
			op_a = {pl_e[CW-1], pl_e};
			op_b = {g_q[ax][CW-1], g_q[ax]};
		end else begin
			op_a = {2'b00, h_q[ax]};
			op_b = pl_e[CW-1] ? -{pl_e[CW-1], pl_e} : {pl_e[CW-1], pl_e};
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = S_MUL;
				end
			end
			S_MUL: state_d = S_ACC;
			S_ACC: begin
				if (last_term && (grp_q == 4'd8)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_MUL;
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			grp_q   <= '0;
			term_q  <= '0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				grp_q  <= '0;
				term_q <= '0;
			end else if (state_q == S_ACC) begin
				if (last_term) begin
					term_q <= '0;
					if (grp_q != 4'd8) begin
						grp_q <= grp_q + 4'd1;
					end
				end else begin
					term_q <= term_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			c_q      <= job.c;
			h_q      <= job.h;
			acc_q    <= init_first;
			inside_q <= 1'b1;
		end
		if (state_q == S_MUL) begin
			prod_q <= op_a * op_b;
		end
		if (state_q == S_ACC) begin
			if (!last_term) begin
				acc_q <= sum;
			end else begin
				acc_q <= init_next;
				if (grp_q < 4'd3) begin
					g_q[grp_q[1:0]] <= g_sat;
				end else if (sum[ACC_W-1]) begin
					inside_q <= 1'b0;
				end
			end
		end
	end

	assign idle   = (state_q == S_IDLE);
	assign done   = (state_q == S_DONE);
	assign result = '{inside_q, c_q[0], c_q[1], c_q[2], h_q[0], h_q[1], h_q[2]};

`ifndef ASSERT_OFF
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held two cycles");
	a_mul_then_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |=> (state_q == S_ACC)) else $error("multiply not accumulated");
	a_grp_range: assert property (@(posedge clk) disable iff (!arst_n)
		grp_q <= 4'd8 && term_q <= 3'd5) else $error("sequencer counter out of range");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (idle && !q_empty)) else $error("pop outside idle");
`endif

endmodule

[design/aabb_frustum_cull_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_frustum_cull_unit
// Builds an axis-aligned box from vertices and tests its transformed center
// against six frustum planes.
// ----------------------------------------------------------------------------
// Channel   Handshake       Payload
// input     start / busy    item   (item_t)
// result    done (strobe)   result (result_t)
//
// A vertex or load item is taken while start is high and busy is low;
// vertices may arrive every cycle while busy stays low. The last vertex
// queues a job; its 9 transform and 36 plane products share one multiplier.
// busy rises when the two-entry job queue is full, or while a load waits for
// the sequencer to drain. Reset clears the box and all control state.
// The result is shown for one cycle and cannot be stalled.
module aabb_frustum_cull_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  afc_pkg::item_t   item,
	output logic             busy,
	output logic             done,
	output afc_pkg::result_t result
);
	import afc_pkg::*;

	q_ctrl_t qc;
	job_t    push_job, pop_job;
	logic    back_idle;
	coef_t   rows [ROW_COUNT];
	coef_t   planes [PLANE_COUNT];

	afc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.back_idle (back_idle),
		.q_full    (qc.full),
		.q_empty   (qc.empty),
		.push      (qc.push),
		.push_job  (push_job),
		.rows      (rows),
		.planes    (planes)
	);

	afc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (qc.push),
		.push_job (push_job),
		.pop      (qc.pop),
		.pop_job  (pop_job),
		.full     (qc.full),
		.empty    (qc.empty)
	);

	afc_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (qc.empty),
		.job     (pop_job),
		.pop     (qc.pop),
		.idle    (back_idle),
		.rows    (rows),
		.planes  (planes),
		.done    (done),
		.result  (result)
	);

endmodule
